>>> rtl/core/plt_pkg.sv
// shared types and constants for the piecewise linear lookup core
package plt_pkg;

  localparam int X_W = 16;
  localparam int Y_W = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] OUT_INTERP = 2'd0;
  localparam logic [1:0] OUT_HIT    = 2'd1;
  localparam logic [1:0] OUT_BELOW  = 2'd2;
  localparam logic [1:0] OUT_ABOVE  = 2'd3;

  localparam logic [2:0] REG_ENTRIES = 3'd0;

  typedef struct packed {
    logic                  op;
    logic [3:0]            entry_index;
    logic [X_W-1:0]        entry_x;
    logic signed [Y_W-1:0] entry_y;
    logic [X_W-1:0]        lookup_value;
  } in_word_t;

  typedef struct packed {
    logic signed [Y_W-1:0] result_value;
    logic [1:0]            outcome;
  } out_word_t;

  typedef struct packed {
    logic           en;
    logic [3:0]     idx;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } load_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic           valid;
    logic           found;
    logic [1:0]     kind;
    logic [X_W-1:0] val;
    logic [Y_W-1:0] y_res;
    logic [Y_W-1:0] y_right;
    logic [X_W-1:0] a;
    logic [X_W-1:0] d;
    logic [Y_W-1:0] y_top;
  } wave_t;

endpackage

>>> rtl/core/piecewise_linear_table_lookup_core.sv
// top level of the piecewise linear lookup core: cell row, divider, control
// load word: written into its cell at the accepting edge
// lookup word: token walks the whole cell row, registered in each cell, from the top cell down
// exact hit or clamp: result goes from the bottom cell through the DONE state into the output register
// interpolation adds the divider between them: a registered multiply, then a restoring divide
// one lookup in flight; rst_n (sync, active low) sets entries_in_use to 16, table undefined
module piecewise_linear_table_lookup_core import plt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [4:0]     entries_r;
  logic [6:0]     cnt;
  logic [IW-1:0]  top_idx;
  load_t          ld;
  wave_t          wave [TABLE_DEPTH+1];
  logic [X_W-1:0] xq [TABLE_DEPTH];
  logic [Y_W-1:0] yq [TABLE_DEPTH];
  logic           in_acc;
  logic           cfg_wr;

  // result side
  logic signed [Y_W-1:0] res_r;
  logic [1:0]            kind_r;
  logic signed [Y_W-1:0] yl_r;
  logic                  neg_r;
  out_word_t             out_r;
  logic                  out_valid_r;

  // divider hookup
  logic                  div_start;
  logic signed [Y_W:0]   dy;
  logic                  dy_neg;
  logic [Y_W:0]          dy_mag;
  logic                  div_done;
  logic [Y_W-1:0]        div_q;
  logic signed [Y_W:0]   interp;
  wave_t                 bot;

  // ---------------- configuration register ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_ENTRIES) ? {27'd0, entries_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= 5'd16;
    end else if (cfg_wr && (cfg_paddr == REG_ENTRIES)) begin
      entries_r <= cfg_pwdata[4:0];
    end
  end

  // zero counts as one entry, anything past the table saturates
  always_comb begin
    cnt = (entries_r == 5'd0) ? 7'd1 : {2'b00, entries_r};
    if (cnt > 7'(TABLE_DEPTH)) begin
      cnt = 7'(TABLE_DEPTH);
    end
  end
  assign top_idx = IW'(cnt - 7'd1);

  // ---------------- input side ----------------
  // next word is taken once the previous lookup has its result parked
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign ld.en  = in_acc && (in_word.op == OP_LOAD);
  assign ld.idx = in_word.entry_index;
  assign ld.x   = in_word.entry_x;
  assign ld.y   = in_word.entry_y;

  // token injected at the top cell of the row
  always_comb begin
    wave[TABLE_DEPTH]       = '0;
    wave[TABLE_DEPTH].valid = in_acc && (in_word.op == OP_LOOKUP);
    wave[TABLE_DEPTH].val   = in_word.lookup_value;
  end

  // ---------------- cell row ----------------
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic [X_W-1:0] nx;
    logic [Y_W-1:0] ny;
    if (k == 0) begin : g_bottom
      assign nx = '0;
      assign ny = '0;
    end else begin : g_upper
      assign nx = xq[k-1];
      assign ny = yq[k-1];
    end
    plt_cell #(.K(k), .IW(IW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ld       (ld),
      .top_idx  (top_idx),
      .x_lo     (nx),
      .y_lo     (ny),
      .wave_in  (wave[k+1]),
      .x_q      (xq[k]),
      .y_q      (yq[k]),
      .wave_out (wave[k])
    );
  end

  assign bot = wave[0];

  // ---------------- interpolation ----------------
  // slope sign handled apart so the divider sees magnitudes only
  assign dy        = {bot.y_right[Y_W-1], bot.y_right} - {bot.y_res[Y_W-1], bot.y_res};
  assign dy_neg    = dy[Y_W];
  assign dy_mag    = dy_neg ? (Y_W+1)'(-dy) : dy;
  assign div_start = (state_r == ST_SEARCH) && bot.valid && (bot.kind == OUT_INTERP);

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (dy_mag[Y_W-1:0]),
    .a     (bot.a),
    .d     (bot.d),
    .done  (div_done),
    .q     (div_q)
  );

  // result stays between the two bracketing y values, so no overflow
  assign interp = neg_r ? ({yl_r[Y_W-1], yl_r} - {1'b0, div_q})
                        : ({yl_r[Y_W-1], yl_r} + {1'b0, div_q});

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_word.op == OP_LOOKUP)) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (bot.valid) state_nxt = (bot.kind == OUT_INTERP) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SEARCH) && bot.valid) begin
      res_r  <= bot.y_res;
      kind_r <= bot.kind;
      yl_r   <= bot.y_res;
      neg_r  <= dy_neg;
    end
    if ((state_r == ST_DIV) && div_done) begin
      res_r <= interp[Y_W-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_r.result_value <= res_r;
      out_r.outcome      <= kind_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word.op == OP_LOOKUP)) |=> (state_r == ST_SEARCH))
    else $error("accepted lookup did not start a search");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV)) else $error("divider finished outside divide phase");

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    bot.valid |-> (state_r == ST_SEARCH)) else $error("search token left row outside search");
`endif

endmodule

>>> rtl/core/plt_cell.sv
// one breakpoint cell: holds an x/y pair and checks the passing search token
module plt_cell import plt_pkg::*; #(
  parameter int K  = 0,
  parameter int IW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  load_t          ld,
  input  logic [IW-1:0]  top_idx,
  input  logic [X_W-1:0] x_lo,
  input  logic [Y_W-1:0] y_lo,
  input  wave_t          wave_in,
  output logic [X_W-1:0] x_q,
  output logic [Y_W-1:0] y_q,
  output wave_t          wave_out
);

  localparam logic [IW-1:0] KI = IW'(K);

  logic [X_W-1:0] x_r;
  logic [Y_W-1:0] y_r;
  wave_t          wave_r;
  wave_t          wave_nxt;
  logic           active;

  assign active = (KI <= top_idx);

  always_comb begin
    wave_nxt = wave_in;
    if (wave_in.valid && active) begin
      if (top_idx == KI) begin
        wave_nxt.y_top = y_r;
      end
      if (!wave_in.found) begin
        if (wave_in.val == x_r) begin
          wave_nxt.found = 1'b1;
          wave_nxt.kind  = OUT_HIT;
          wave_nxt.y_res = y_r;
        end else if ((K != 0) && (wave_in.val < x_r) && (wave_in.val > x_lo)) begin
          wave_nxt.found   = 1'b1;
          wave_nxt.kind    = OUT_INTERP;
          wave_nxt.y_res   = y_lo;
          wave_nxt.y_right = y_r;
          wave_nxt.a       = wave_in.val - x_lo;
          wave_nxt.d       = x_r - x_lo;
        end else if (K == 0) begin
          // nothing bracketed the value: clamp to an end of the table
          wave_nxt.found = 1'b1;
          if (wave_in.val < x_r) begin
            wave_nxt.kind  = OUT_BELOW;
            wave_nxt.y_res = y_r;
          end else begin
            wave_nxt.kind  = OUT_ABOVE;
            wave_nxt.y_res = (top_idx == KI) ? y_r : wave_in.y_top;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.en && (32'(ld.idx) == K)) begin
      x_r <= ld.x;
      y_r <= ld.y;
    end
    wave_r <= wave_nxt;
    if (!rst_n) begin
      wave_r.valid <= 1'b0;
    end
  end

  assign x_q      = x_r;
  assign y_q      = y_r;
  assign wave_out = wave_r;

endmodule

>>> rtl/core/plt_div.sv
// multiply then restoring divide, one quotient bit per cycle
module plt_div import plt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [Y_W-1:0] mag,
  input  logic [X_W-1:0] a,
  input  logic [X_W-1:0] d,
  output logic           done,
  output logic [Y_W-1:0] q
);

  localparam int PW = X_W + Y_W;
  localparam int CW = $clog2(Y_W + 1);

  logic [PW-1:0]  prod_r;
  logic [X_W-1:0] d_r;
  logic [X_W-1:0] rem_r;
  logic [Y_W-1:0] low_r;
  logic [Y_W-1:0] q_r;
  logic [CW-1:0]  cnt_r;
  logic           mul_r;
  logic           run_r;
  logic           done_r;
  logic [X_W:0]   trial;
  logic           ge;
  logic [X_W:0]   diff;

  assign trial = {rem_r, low_r[Y_W-1]};
  assign ge    = (trial >= {1'b0, d_r});
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      mul_r  <= start;
      if (mul_r) begin
        run_r <= 1'b1;
        cnt_r <= CW'(Y_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'({{X_W{1'b0}}, mag} * {{Y_W{1'b0}}, a});
      d_r    <= d;
    end
    if (mul_r) begin
      rem_r <= prod_r[PW-1:Y_W];
      low_r <= prod_r[Y_W-1:0];
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[X_W-1:0] : trial[X_W-1:0];
      low_r <= {low_r[Y_W-2:0], 1'b0};
      q_r   <= {q_r[Y_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
